/* src/hgov_pkg.sv */
// Shared types, constants and direction tables for the HOG orientation voter.
`default_nettype none
package hgov_pkg;

    localparam int MAX_IMAGE_SIDE = 1024;
    localparam int NUM_DIRS       = 9;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_WIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_HIGH = 2'd2;

    localparam int FRAC_W     = 16;
    localparam int DIV_NUM_W  = 12;
    localparam int DIV_W      = DIV_NUM_W + FRAC_W;
    localparam int DEN_W      = 7;
    localparam int DIV_STAGES = 7;
    localparam int DIV_STEP   = 4;

    localparam int SQ_IN_W    = 17;
    localparam int SQ_ROOT_W  = 17;
    localparam int SQ_STAGES  = 7;
    localparam int SQ_STEP    = 3;

    localparam int PIPE_LAT   = 7;
    localparam int ORIENT_PAD = PIPE_LAT - 3;

    localparam int BIN_W  = 5;
    localparam int VOTE_W = 17;

    typedef struct packed {
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [23:0] above_rgb;
        logic [23:0] below_rgb;
        logic [23:0] left_rgb;
        logic [23:0] right_rgb;
    } hgov_in_t;

    typedef struct packed {
        logic [7:0]        cell_col;
        logic [7:0]        cell_row;
        logic [BIN_W-1:0]  orient_bin;
        logic [VOTE_W-1:0] vote_value;
        logic              last_vote;
    } hgov_out_t;

    typedef struct packed {
        logic [8:0] cols;
        logic [8:0] rows;
    } hgov_grid_t;

    function automatic logic signed [14:0] unit_x(input logic [3:0] k);
        logic signed [14:0] v;
        case (k)
            4'd0:    v = 15'sd10000;
            4'd1:    v = 15'sd9397;
            4'd2:    v = 15'sd7660;
            4'd3:    v = 15'sd5000;
            4'd4:    v = 15'sd1736;
            4'd5:    v = -15'sd1736;
            4'd6:    v = -15'sd5000;
            4'd7:    v = -15'sd7660;
            4'd8:    v = -15'sd9397;
            default: v = 15'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [14:0] unit_y(input logic [3:0] k);
        logic signed [14:0] v;
        case (k)
            4'd0:    v = 15'sd0;
            4'd1:    v = 15'sd3420;
            4'd2:    v = 15'sd6428;
            4'd3:    v = 15'sd8660;
            4'd4:    v = 15'sd9848;
            4'd5:    v = 15'sd9848;
            4'd6:    v = 15'sd8660;
            4'd7:    v = 15'sd6428;
            4'd8:    v = 15'sd3420;
            default: v = 15'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/hgov_orient.sv */
// Orientation snap: nine dot products, two-stage maximum search, alignment delay.
`default_nettype none
module hgov_orient
    import hgov_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic signed [8:0] gx,
    input  wire logic signed [8:0] gy,
    output logic [BIN_W-1:0]       bin
);

    logic signed [23:0] d_reg [NUM_DIRS];
    logic signed [23:0] d_next [NUM_DIRS];
    logic signed [23:0] dh_reg [4];
    logic signed [24:0] top3_reg, top3_next;
    logic [BIN_W-1:0]   bin3_reg, bin3_next;
    logic [BIN_W-1:0]   bin4_reg, bin4_next;
    logic [BIN_W-1:0]   pad_reg [ORIENT_PAD];

    always_comb
    begin
        for (int k = 0; k < NUM_DIRS; k++)
        begin
            d_next[k] = unit_x(4'(k)) * gx + unit_y(4'(k)) * gy;
        end
    end

    always_comb
    begin
        logic signed [24:0] dd;
        logic signed [24:0] nd;
        top3_next = '0;
        bin3_next = '0;
        for (int k = 0; k < 5; k++)
        begin
            dd = 25'(d_reg[k]);
            nd = -dd;
            if (dd > top3_next)
            begin
                top3_next = dd;
                bin3_next = BIN_W'(k);
            end
            else if (nd > top3_next)
            begin
                top3_next = nd;
                bin3_next = BIN_W'(k + NUM_DIRS);
            end
        end
    end

    always_comb
    begin
        logic signed [24:0] top;
        logic signed [24:0] dd;
        logic signed [24:0] nd;
        top       = top3_reg;
        bin4_next = bin3_reg;
        for (int k = 0; k < 4; k++)
        begin
            dd = 25'(dh_reg[k]);
            nd = -dd;
            if (dd > top)
            begin
                top       = dd;
                bin4_next = BIN_W'(k + 5);
            end
            else if (nd > top)
            begin
                top       = nd;
                bin4_next = BIN_W'(k + 5 + NUM_DIRS);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_DIRS; k++)
            begin
                d_reg[k] <= d_next[k];
            end
            for (int k = 0; k < 4; k++)
            begin
                dh_reg[k] <= d_reg[k + 5];
            end
            top3_reg <= top3_next;
            bin3_reg <= bin3_next;
            bin4_reg <= bin4_next;
            pad_reg[0] <= bin4_reg;
            for (int k = 1; k < ORIENT_PAD; k++)
            begin
                pad_reg[k] <= pad_reg[k-1];
            end
        end
    end

    assign bin = pad_reg[ORIENT_PAD-1];

endmodule
`default_nettype wire

/* src/hgov_sqrt.sv */
// Pipelined integer square root of a value scaled by 2^16, a few root bits per stage.
`default_nettype none
module hgov_sqrt
    import hgov_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [SQ_IN_W-1:0]   val,
    output logic [SQ_ROOT_W-1:0]      root
);

    localparam int N_W = 2 * SQ_ROOT_W;
    localparam int R_W = SQ_ROOT_W + 1;

    logic [R_W-1:0]       rem_reg  [SQ_STAGES];
    logic [R_W-1:0]       rem_next [SQ_STAGES];
    logic [SQ_ROOT_W-1:0] rt_reg   [SQ_STAGES];
    logic [SQ_ROOT_W-1:0] rt_next  [SQ_STAGES];
    logic [N_W-1:0]       n_reg    [SQ_STAGES];
    logic [N_W-1:0]       n_next   [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_st
        logic [R_W-1:0]       rem_in;
        logic [SQ_ROOT_W-1:0] rt_in;
        logic [N_W-1:0]       n_in;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign n_in   = N_W'({val, {FRAC_W{1'b0}}});
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign rt_in  = rt_reg[s-1];
            assign n_in   = n_reg[s-1];
        end

        always_comb
        begin
            logic [R_W+1:0]       t;
            logic [R_W+1:0]       trial;
            logic [R_W-1:0]       r;
            logic [SQ_ROOT_W-1:0] q;
            logic [N_W-1:0]       n;
            r = rem_in;
            q = rt_in;
            n = n_in;
            for (int i = 0; i < SQ_STEP; i++)
            begin
                if (s * SQ_STEP + i < SQ_ROOT_W)
                begin
                    t     = {r, n[N_W-1 -: 2]};
                    n     = {n[N_W-3:0], 2'b00};
                    trial = (R_W+2)'({q, 2'b01});
                    if (t >= trial)
                    begin
                        t = t - trial;
                        q = {q[SQ_ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[SQ_ROOT_W-2:0], 1'b0};
                    end
                    r = t[R_W-1:0];
                end
            end
            rem_next[s] = r;
            rt_next[s]  = q;
            n_next[s]   = n;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[s];
                rt_reg[s]  <= rt_next[s];
                n_reg[s]   <= n_next[s];
            end
        end
    end

    assign root = rt_reg[SQ_STAGES-1];

endmodule
`default_nettype wire

/* src/hgov_div.sv */
// Pipelined restoring divider: (num * 2^16) / den, a few quotient bits per stage.
`default_nettype none
module hgov_div
    import hgov_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]     den,
    output logic [DIV_W-1:0]          quo
);

    logic [DEN_W-1:0] a_reg  [DIV_STAGES];
    logic [DEN_W-1:0] a_next [DIV_STAGES];
    logic [DIV_W-1:0] q_reg  [DIV_STAGES];
    logic [DIV_W-1:0] q_next [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_st
        logic [DEN_W-1:0] a_in;
        logic [DIV_W-1:0] q_in;

        if (s == 0)
        begin : g_first
            assign a_in = '0;
            assign q_in = {num, {FRAC_W{1'b0}}};
        end
        else
        begin : g_rest
            assign a_in = a_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        always_comb
        begin
            logic [DEN_W:0]   t;
            logic [DEN_W-1:0] a;
            logic [DIV_W-1:0] q;
            a = a_in;
            q = q_in;
            for (int i = 0; i < DIV_STEP; i++)
            begin
                if (s * DIV_STEP + i < DIV_W)
                begin
                    t = {a, q[DIV_W-1]};
                    q = {q[DIV_W-2:0], 1'b0};
                    if (t >= {1'b0, den})
                    begin
                        t    = t - {1'b0, den};
                        q[0] = 1'b1;
                    end
                    a = t[DEN_W-1:0];
                end
            end
            a_next[s] = a;
            q_next[s] = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[s] <= a_next[s];
                q_reg[s] <= q_next[s];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

/* src/hgov_vote.sv */
// Bilinear vote lanes (grid test, weight products) and the vote serializer.
`default_nettype none
module hgov_vote
    import hgov_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid,
    input  wire logic                 keep,
    input  wire logic [BIN_W-1:0]     bin,
    input  wire logic [SQ_ROOT_W-1:0] mag,
    input  wire logic [DIV_W-1:0]     quo_x,
    input  wire logic [DIV_W-1:0]     quo_y,
    input  wire hgov_grid_t           grid,
    output logic                      can_advance,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hgov_out_t                 out_data
);

    logic                 v9_reg, v10_reg;
    logic [3:0]           m9_reg, m9_next, m10_reg;
    logic [7:0]           col9_reg [4];
    logic [7:0]           row9_reg [4];
    logic [7:0]           col9_next [4];
    logic [7:0]           row9_next [4];
    logic [32:0]          w9_reg [4];
    logic [32:0]          w9_next [4];
    logic [SQ_ROOT_W-1:0] mag9_reg;
    logic [BIN_W-1:0]     bin9_reg, bin10_reg;
    logic [7:0]           col10_reg [4];
    logic [7:0]           row10_reg [4];
    logic [VOTE_W-1:0]    vv10_reg [4];
    logic [VOTE_W-1:0]    vv10_next [4];

    logic [3:0]           ser_mask_reg, ser_mask_next;
    logic [7:0]           ser_col_reg [4];
    logic [7:0]           ser_row_reg [4];
    logic [VOTE_W-1:0]    ser_vv_reg [4];
    logic [BIN_W-1:0]     ser_bin_reg;

    logic [1:0]           sel;
    logic [3:0]           low;
    logic [3:0]           remaining;
    logic                 can_load;

    always_comb
    begin
        logic signed [12:0] ix;
        logic signed [12:0] iy;
        logic signed [12:0] q;
        logic signed [12:0] r;
        logic [16:0]        wx [2];
        logic [16:0]        wy [2];
        logic [33:0]        p;
        ix = $signed({1'b0, quo_x[DIV_W-1:FRAC_W]}) - 13'sd1;
        iy = $signed({1'b0, quo_y[DIV_W-1:FRAC_W]}) - 13'sd1;
        wx[0] = 17'h10000 - {1'b0, quo_x[FRAC_W-1:0]};
        wx[1] = {1'b0, quo_x[FRAC_W-1:0]};
        wy[0] = 17'h10000 - {1'b0, quo_y[FRAC_W-1:0]};
        wy[1] = {1'b0, quo_y[FRAC_W-1:0]};
        for (int k = 0; k < 4; k++)
        begin
            q = ix + 13'(k & 1);
            r = iy + 13'(k >> 1);
            m9_next[k] = keep && (q >= 13'sd0) && (q < $signed({4'b0, grid.cols}))
                      && (r >= 13'sd0) && (r < $signed({4'b0, grid.rows}));
            col9_next[k] = q[7:0];
            row9_next[k] = r[7:0];
            p = wy[k >> 1] * wx[k & 1];
            w9_next[k] = p[32:0];
        end
    end

    always_comb
    begin
        logic [49:0] p;
        for (int k = 0; k < 4; k++)
        begin
            p = w9_reg[k] * mag9_reg;
            vv10_next[k] = p[32 +: VOTE_W];
        end
    end

    always_comb
    begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (ser_mask_reg[k])
            begin
                sel = 2'(k);
            end
        end
        low = 4'b0001 << sel;
    end

    assign out_valid   = |ser_mask_reg;
    assign remaining   = (out_valid && out_ready) ? (ser_mask_reg & ~low) : ser_mask_reg;
    assign can_load    = (remaining == 4'b0000);
    assign can_advance = !v10_reg || can_load;

    always_comb
    begin
        if (can_load)
        begin
            ser_mask_next = v10_reg ? m10_reg : 4'b0000;
        end
        else
        begin
            ser_mask_next = remaining;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg       <= 1'b0;
            v10_reg      <= 1'b0;
            ser_mask_reg <= 4'b0000;
        end
        else
        begin
            if (en)
            begin
                v9_reg  <= valid;
                v10_reg <= v9_reg;
            end
            ser_mask_reg <= ser_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m9_reg    <= m9_next;
            mag9_reg  <= mag;
            bin9_reg  <= bin;
            m10_reg   <= m9_reg;
            bin10_reg <= bin9_reg;
            for (int k = 0; k < 4; k++)
            begin
                col9_reg[k]  <= col9_next[k];
                row9_reg[k]  <= row9_next[k];
                w9_reg[k]    <= w9_next[k];
                col10_reg[k] <= col9_reg[k];
                row10_reg[k] <= row9_reg[k];
                vv10_reg[k]  <= vv10_next[k];
            end
        end
        if (can_load && v10_reg)
        begin
            ser_bin_reg <= bin10_reg;
            for (int k = 0; k < 4; k++)
            begin
                ser_col_reg[k] <= col10_reg[k];
                ser_row_reg[k] <= row10_reg[k];
                ser_vv_reg[k]  <= vv10_reg[k];
            end
        end
    end

    always_comb
    begin
        out_data.cell_col   = ser_col_reg[sel];
        out_data.cell_row   = ser_row_reg[sel];
        out_data.orient_bin = ser_bin_reg;
        out_data.vote_value = ser_vv_reg[sel];
        out_data.last_vote  = ((ser_mask_reg & ~low) == 4'b0000);
    end

endmodule
`default_nettype wire

/* src/hog_gradient_orientation_voter_unit.sv */
// Top level: gradient select stage, divider/sqrt/orientation pipes and vote output.
// Throughput: one pixel per cycle while each pixel gives at most one vote and out_ready
// is high; a pixel with more votes holds the single-vote output port, stalling the pipe.
// Pipeline depth is set by the 7-stage divider and square-root units.
// Reset clears all valid bits and loads cell side 4, cells_wide 64, cells_high 64.
`default_nettype none
module hog_gradient_orientation_voter_unit
    import hgov_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hgov_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hgov_out_t                  out_data,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [5:0]           cell_side_reg;
    logic [8:0]           cells_wide_reg;
    logic [8:0]           cells_high_reg;
    logic [5:0]           s_eff;
    hgov_grid_t           grid;

    logic                 en;
    logic                 can_advance;
    logic                 v_reg [PIPE_LAT+1];
    logic                 k_reg [PIPE_LAT+1];
    logic                 keep_next;

    logic signed [8:0]    gx_reg, gx_next;
    logic signed [8:0]    gy_reg, gy_next;
    logic [SQ_IN_W-1:0]   best_reg, best_next;
    logic [DIV_NUM_W-1:0] nx_reg, nx_next;
    logic [DIV_NUM_W-1:0] ny_reg, ny_next;

    logic [BIN_W-1:0]     bin;
    logic [SQ_ROOT_W-1:0] mag;
    logic [DIV_W-1:0]     quo_x;
    logic [DIV_W-1:0]     quo_y;

    assign s_eff     = (cell_side_reg == 6'd0) ? 6'd1 : cell_side_reg;
    assign grid.cols = (cells_wide_reg > 9'd256) ? 9'd256 : cells_wide_reg;
    assign grid.rows = (cells_high_reg > 9'd256) ? 9'd256 : cells_high_reg;

    assign en       = can_advance;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_side_reg  <= 6'd4;
            cells_wide_reg <= 9'd64;
            cells_high_reg <= 9'd64;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_CELL_SIDE:  cell_side_reg  <= cfg_data[5:0];
                CFG_CELLS_WIDE: cells_wide_reg <= cfg_data;
                CFG_CELLS_HIGH: cells_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic signed [8:0]  gx;
        logic signed [8:0]  gy;
        logic signed [17:0] sx;
        logic signed [17:0] sy;
        logic [16:0]        e;
        best_next = '0;
        gx_next   = '0;
        gy_next   = '0;
        for (int c = 0; c < 3; c++)
        begin
            gx = $signed({1'b0, in_data.right_rgb[16-8*c +: 8]})
               - $signed({1'b0, in_data.left_rgb[16-8*c +: 8]});
            gy = $signed({1'b0, in_data.below_rgb[16-8*c +: 8]})
               - $signed({1'b0, in_data.above_rgb[16-8*c +: 8]});
            sx = gx * gx;
            sy = gy * gy;
            e  = sx[16:0] + sy[16:0];
            if (c == 0 || e > best_next)
            begin
                best_next = e;
                gx_next   = gx;
                gy_next   = gy;
            end
        end
        nx_next   = {1'b0, in_data.pos_x, 1'b1} + DIV_NUM_W'(s_eff);
        ny_next   = {1'b0, in_data.pos_y, 1'b1} + DIV_NUM_W'(s_eff);
        keep_next = (13'(in_data.pos_x) < 13'(MAX_IMAGE_SIDE))
                 && (13'(in_data.pos_y) < 13'(MAX_IMAGE_SIDE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PIPE_LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= PIPE_LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            best_reg <= best_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            k_reg[0] <= keep_next;
            for (int i = 1; i <= PIPE_LAT; i++)
            begin
                k_reg[i] <= k_reg[i-1];
            end
        end
    end

    hgov_orient u_orient (
        .clk (clk),
        .en  (en),
        .gx  (gx_reg),
        .gy  (gy_reg),
        .bin (bin)
    );

    hgov_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .val  (best_reg),
        .root (mag)
    );

    hgov_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (nx_reg),
        .den ({s_eff, 1'b0}),
        .quo (quo_x)
    );

    hgov_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (ny_reg),
        .den ({s_eff, 1'b0}),
        .quo (quo_y)
    );

    hgov_vote u_vote (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid       (v_reg[PIPE_LAT]),
        .keep        (k_reg[PIPE_LAT]),
        .bin         (bin),
        .mag         (mag),
        .quo_x       (quo_x),
        .quo_y       (quo_y),
        .grid        (grid),
        .can_advance (can_advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    a_stall_needs_vote: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no vote pending");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.orient_bin <= BIN_W'(2 * NUM_DIRS - 1)))
        else $error("orientation bin out of range");

    a_vote_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.vote_value <= 17'd92416))
        else $error("vote value above magnitude limit");

endmodule
`default_nettype wire

/* sim/tb_hog_gradient_orientation_voter_unit.sv */
// Self-checking testbench for the HOG orientation voter: random pixels, grids and handshake gaps.
module tb_hog_gradient_orientation_voter_unit
    import hgov_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    hgov_in_t in_data;
    logic out_valid;
    logic out_ready;
    hgov_out_t out_data;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hgov_in_t pixel_queue[$];
    hgov_out_t vote_queue[$];
    int unsigned mismatches;
    bit in_taken;
    int unsigned grid_size;
    int unsigned grid_cols;
    int unsigned grid_rows;
    int unsigned drv_gap;
    int unsigned mon_gap;

    hog_gradient_orientation_voter_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    task automatic cell_locate(input int pos, input int s, output int idx,
                               output longint unsigned frac);
        int num;
        int den;
        int q;
        num = 2 * pos + 1 - s;
        den = 2 * s;
        if (num >= 0)
            q = num / den;
        else
            q = -(((-num) + den - 1) / den);
        idx = q;
        frac = (longint'(num - q * den) << 16) / den;
    endtask

    task automatic predict_votes(input hgov_in_t p);
        int s;
        int cw;
        int ch;
        int gx;
        int gy;
        int e;
        int dx;
        int dy;
        int best;
        int d;
        int top;
        int bin;
        int ix;
        int iy;
        int r;
        int q;
        int n;
        longint unsigned mag;
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned wx[2];
        longint unsigned wy[2];
        hgov_out_t v;
        s = (grid_size == 0) ? 1 : grid_size;
        cw = (grid_cols > 256) ? 256 : grid_cols;
        ch = (grid_rows > 256) ? 256 : grid_rows;
        if (p.pos_x >= MAX_IMAGE_SIDE || p.pos_y >= MAX_IMAGE_SIDE)
            return;
        best = 0;
        dx = 0;
        dy = 0;
        for (int c = 0; c < 3; c++)
        begin
            gx = int'(p.right_rgb[16 - 8 * c +: 8]) - int'(p.left_rgb[16 - 8 * c +: 8]);
            gy = int'(p.below_rgb[16 - 8 * c +: 8]) - int'(p.above_rgb[16 - 8 * c +: 8]);
            e = gx * gx + gy * gy;
            if (c == 0 || e > best)
            begin
                best = e;
                dx = gx;
                dy = gy;
            end
        end
        top = 0;
        bin = 0;
        for (int k = 0; k < NUM_DIRS; k++)
        begin
            d = int'(unit_x(4'(k))) * dx + int'(unit_y(4'(k))) * dy;
            if (d > top)
            begin
                top = d;
                bin = k;
            end
            else if (-d > top)
            begin
                top = -d;
                bin = k + NUM_DIRS;
            end
        end
        mag = int_sqrt(longint'(best) << 16);
        cell_locate(p.pos_x, s, ix, fx);
        cell_locate(p.pos_y, s, iy, fy);
        wx[0] = 65536 - fx;
        wx[1] = fx;
        wy[0] = 65536 - fy;
        wy[1] = fy;
        n = 0;
        for (int k = 0; k < 4; k++)
        begin
            r = iy + (k >> 1);
            q = ix + (k & 1);
            if (r >= 0 && r < ch && q >= 0 && q < cw)
            begin
                v.cell_col = q[7:0];
                v.cell_row = r[7:0];
                v.orient_bin = bin[4:0];
                v.vote_value = 17'((wy[k >> 1] * wx[k & 1] * mag) >> 32);
                v.last_vote = 1'b0;
                vote_queue.push_back(v);
                n++;
            end
        end
        if (n > 0)
            vote_queue[$].last_vote = 1'b1;
    endtask

    // hold payload until the transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    in_data <= pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    drv_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
            if (mon_gap > 0)
            begin
                mon_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    mon_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        hgov_out_t exp_vote;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            predict_votes(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            if (vote_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vote %p", out_data);
            end
            else
            begin
                exp_vote = vote_queue.pop_front();
                if (out_data.cell_col !== exp_vote.cell_col
                    || out_data.cell_row !== exp_vote.cell_row
                    || out_data.orient_bin !== exp_vote.orient_bin
                    || out_data.vote_value !== exp_vote.vote_value
                    || out_data.last_vote !== exp_vote.last_vote)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vote mismatch: expected %p actual %p", exp_vote, out_data);
                end
            end
        end
    end

    function automatic logic [23:0] rand_rgb();
        return 24'($urandom);
    endfunction

    function automatic hgov_in_t rand_pixel(int unsigned span);
        hgov_in_t p;
        p.pos_x = 10'($urandom_range(0, span));
        p.pos_y = 10'($urandom_range(0, span));
        p.above_rgb = rand_rgb();
        p.below_rgb = rand_rgb();
        p.left_rgb = rand_rgb();
        p.right_rgb = rand_rgb();
        if ($urandom_range(0, 9) == 0)
            p.pos_x = 10'($urandom);
        return p;
    endfunction

    task automatic drain();
        while (pixel_queue.size() > 0 || in_valid || vote_queue.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned s, input int unsigned cols,
                            input int unsigned rows);
        drain();
        write_reg(CFG_CELL_SIDE, s);
        write_reg(CFG_CELLS_WIDE, cols);
        write_reg(CFG_CELLS_HIGH, rows);
        grid_size = s & 6'h3f;
        grid_cols = cols;
        grid_rows = rows;
    endtask

    task automatic push_dir(input int dr, input int dg, input int db, input int vr,
                            input int vg, input int vb, input int px, input int py);
        hgov_in_t p;
        p.pos_x = 10'(px);
        p.pos_y = 10'(py);
        p.left_rgb = {8'(128 - dr), 8'(128 - dg), 8'(128 - db)};
        p.right_rgb = {8'(128 + dr), 8'(128 + dg), 8'(128 + db)};
        p.above_rgb = {8'(128 - vr), 8'(128 - vg), 8'(128 - vb)};
        p.below_rgb = {8'(128 + vr), 8'(128 + vg), 8'(128 + vb)};
        pixel_queue.push_back(p);
    endtask

    initial
    begin
        hgov_in_t p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = CFG_CELL_SIDE;
        cfg_data = '0;
        mismatches = 0;
        in_taken = 1'b0;
        drv_gap = 0;
        mon_gap = 0;
        grid_size = 4;
        grid_cols = 64;
        grid_rows = 64;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero gradient, ties, every axis, extremes of position
        push_dir(0, 0, 0, 0, 0, 0, 0, 0);
        push_dir(10, 10, 10, 0, 0, 0, 5, 5);
        push_dir(0, 20, 0, 0, 0, 0, 6, 9);
        push_dir(0, 0, 0, 0, 0, 30, 7, 3);
        push_dir(-50, 0, 0, 0, 0, 0, 100, 100);
        push_dir(0, 0, 0, 50, 0, 0, 255, 255);
        push_dir(0, 0, 0, -50, 0, 0, 1, 2);
        push_dir(40, 0, 0, 40, 0, 0, 12, 12);
        push_dir(-40, 0, 0, 40, 0, 0, 13, 14);
        push_dir(40, 0, 0, 14, 0, 0, 20, 21);
        push_dir(-7, 0, 0, 40, 0, 0, 30, 31);
        push_dir(127, 127, 127, 127, 127, 127, 1023, 1023);
        push_dir(10, 0, 0, 0, 0, 0, 1024 - 1, 0);
        p = '0;
        p.right_rgb = 24'hffffff;
        p.below_rgb = 24'hffffff;
        pixel_queue.push_back(p);
        p.pos_x = 10'd255;
        p.pos_y = 10'd256;
        p.left_rgb = 24'hffffff;
        p.right_rgb = '0;
        pixel_queue.push_back(p);
        drain();

        set_grid(1, 256, 256);
        repeat (40) pixel_queue.push_back(rand_pixel(300));
        set_grid(32, 1, 1);
        repeat (30) pixel_queue.push_back(rand_pixel(80));
        set_grid(0, 511, 300);
        repeat (30) pixel_queue.push_back(rand_pixel(1023));
        set_grid(7, 0, 10);
        repeat (10) pixel_queue.push_back(rand_pixel(100));
        set_grid(5, 20, 0);
        repeat (5) pixel_queue.push_back(rand_pixel(100));
        set_grid(3, 40, 30);
        repeat (40) pixel_queue.push_back(rand_pixel(130));
        drain();
        set_grid(8, 16, 16);
        repeat (50) pixel_queue.push_back(rand_pixel(140));
        drain();

        if (mismatches == 0)
            $display("hog_gradient_orientation_voter_unit regression: pass");
        else
            $display("hog_gradient_orientation_voter_unit regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("hog_gradient_orientation_voter_unit regression: fail");
        $finish;
    end

endmodule
